[hdl/vsm_pkg.sv]
// ----------------------------------------------------------------------------
// vsm_pkg
// Shared widths, constants and the 2^(-k/16) table for the softmax block.
// ----------------------------------------------------------------------------
package vsm_pkg;

    localparam int DATA_W = 16;   // logit and probability width
    localparam int EXP_W  = 17;   // exp value, 1.0 = 65536
    localparam int SUM_W  = 23;   // sum of exp values
    localparam int U_W    = 33;   // d * log2(e), 24 fraction bits
    localparam int PROD_W = 29;   // (hi - lo) * r

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef logic [EXP_W-1:0] t_exp;

    // 2^(-k/16) in Q16, rounded
    function automatic t_exp pow2_neg(input logic [4:0] k);
        t_exp v;
        unique case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/vsm_exp.sv]
// ----------------------------------------------------------------------------
// vsm_exp
// Three-stage pipeline for exp(x - max) in Q16 via 2^-(d*log2e) with a
// 16-segment interpolated table.
// ----------------------------------------------------------------------------
module vsm_exp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [vsm_pkg::DATA_W-1:0] i_x,
    input  logic signed [vsm_pkg::DATA_W-1:0] i_max,
    output logic                             o_valid,
    output vsm_pkg::t_exp                    o_e
);

    logic [2:0]                     r_vld;
    logic [vsm_pkg::U_W-1:0]        r_u;
    vsm_pkg::t_exp                  r_hi;
    logic [vsm_pkg::PROD_W-1:0]     r_prod;
    logic                           r_big;
    logic [4:0]                     r_sh;
    vsm_pkg::t_exp                  r_e;

    logic signed [vsm_pkg::DATA_W:0] diff;
    logic [vsm_pkg::DATA_W-1:0]      d;
    logic [8:0]                      n_int;
    logic [4:0]                      k;
    logic [11:0]                     frac;
    vsm_pkg::t_exp                   hi;
    vsm_pkg::t_exp                   lo;
    vsm_pkg::t_exp                   t;

    always_comb begin
        diff  = {i_max[vsm_pkg::DATA_W-1], i_max} - {i_x[vsm_pkg::DATA_W-1], i_x};
        d     = diff[vsm_pkg::DATA_W] ? '0 : diff[vsm_pkg::DATA_W-1:0];
        n_int = r_u[32:24];
        k     = {1'b0, r_u[23:20]};
        frac  = r_u[19:8];
        hi    = vsm_pkg::pow2_neg(k);
        lo    = vsm_pkg::pow2_neg(k + 5'd1);
        t     = r_hi - r_prod[28:12];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: scale by log2(e)
        r_u    <= vsm_pkg::U_W'(d) * vsm_pkg::U_W'(vsm_pkg::LOG2E_Q16);
        // stage 2: table lookup and slope product
        r_hi   <= hi;
        r_prod <= vsm_pkg::PROD_W'(hi - lo) * vsm_pkg::PROD_W'(frac);
        r_big  <= (n_int >= 9'd17);
        r_sh   <= n_int[4:0];
        // stage 3: interpolate and apply the integer exponent
        r_e    <= r_big ? '0 : (t >> r_sh);
    end

    assign o_valid = r_vld[2];
    assign o_e     = r_e;

endmodule

[hdl/vector_softmax.sv]
// Sequence: after the item carrying tlast, every stored element is read and
//   passed through exp to form the sum; then results are made one by one.
// Throughput: one input item per cycle while collecting; each result takes a
//   memory read, exp and the 17-step restoring divider before the next starts.
// Reset: synchronous, active low; clears count, max, sum and control. The
//   element memory is not cleared.
// ----------------------------------------------------------------------------
// vector_softmax
// Max-subtracted softmax over a stream of Q8.8 logits, emitting Q0.16
// probabilities in input order once the last element arrives.
// ----------------------------------------------------------------------------
module vector_softmax #(
    parameter int MAX_DIM = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] value
    input  logic        s_axis_tlast,   // is_last_element
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] probability
    output logic        m_axis_tlast    // ends_vector
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);

    localparam logic [2:0] ST_COLLECT = 3'd0;
    localparam logic [2:0] ST_SUM     = 3'd1;
    localparam logic [2:0] ST_RD      = 3'd2;
    localparam logic [2:0] ST_WAIT    = 3'd3;
    localparam logic [2:0] ST_DIV     = 3'd4;
    localparam logic [2:0] ST_OUT     = 3'd5;

    localparam logic signed [15:0] MAX_RESET = 16'sh8000;

    logic [15:0] mem [MAX_DIM];

    logic [2:0]                      r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic signed [15:0]              r_max, n_max;
    logic [vsm_pkg::SUM_W-1:0]       r_sum, n_sum;
    logic [CW-1:0]                   r_idx, n_idx;
    logic [CW-1:0]                   r_got, n_got;
    logic [vsm_pkg::SUM_W-1:0]       r_rem, n_rem;
    logic [16:0]                     r_quo, n_quo;
    logic                            r_ebit, n_ebit;
    logic [4:0]                      r_dcnt, n_dcnt;
    logic                            r_out_vld, n_out_vld;
    logic [15:0]                     r_out_data, n_out_data;
    logic                            r_out_last, n_out_last;
    logic                            r_rd_vld;
    logic [15:0]                     r_rd_data;

    logic                            in_acc;
    logic                            room;
    logic                            rd_en;
    logic                            exp_vld;
    vsm_pkg::t_exp                   exp_e;
    logic [vsm_pkg::SUM_W:0]         shifted;
    logic [vsm_pkg::SUM_W:0]         trial;
    logic                            out_free;

    assign s_axis_tready = (r_state == ST_COLLECT);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign room          = (r_count < CW'(MAX_DIM));
    assign rd_en         = ((r_state == ST_SUM) && (r_idx != r_count)) || (r_state == ST_RD);
    assign out_free      = !r_out_vld || m_axis_tready;

    // element memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc && room) begin
            mem[r_count[AW-1:0]] <= s_axis_tdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_idx[AW-1:0]];
        end
    end

    vsm_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_vld),
        .i_x     (signed'(r_rd_data)),
        .i_max   (r_max),
        .o_valid (exp_vld),
        .o_e     (exp_e)
    );

    always_comb begin
        shifted = {r_rem, ((r_dcnt == 5'd0) ? r_ebit : 1'b0)};
        trial   = shifted - {1'b0, r_sum};
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_max      = r_max;
        n_sum      = r_sum;
        n_idx      = r_idx;
        n_got      = r_got;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_ebit     = r_ebit;
        n_dcnt     = r_dcnt;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;
        n_out_last = r_out_last;

        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_COLLECT: begin
                if (in_acc) begin
                    if (room) begin
                        n_count = r_count + CW'(1);
                        if (signed'(s_axis_tdata) > r_max) begin
                            n_max = signed'(s_axis_tdata);
                        end
                    end
                    if (s_axis_tlast) begin
                        n_state = ST_SUM;
                        n_idx   = '0;
                        n_got   = '0;
                    end
                end
            end
            ST_SUM: begin
                if (rd_en) begin
                    n_idx = r_idx + CW'(1);
                end
                if (exp_vld) begin
                    n_sum = r_sum + vsm_pkg::SUM_W'(exp_e);
                    n_got = r_got + CW'(1);
                    if (n_got == r_count) begin
                        n_state = ST_RD;
                        n_idx   = '0;
                    end
                end
            end
            ST_RD: begin
                n_idx   = r_idx + CW'(1);
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                // dividend is e << 16; preload its top bits
                if (exp_vld) begin
                    n_rem   = vsm_pkg::SUM_W'(exp_e[16:1]);
                    n_ebit  = exp_e[0];
                    n_quo   = '0;
                    n_dcnt  = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!trial[vsm_pkg::SUM_W]) begin
                    n_rem = trial[vsm_pkg::SUM_W-1:0];
                    n_quo = {r_quo[15:0], 1'b1};
                end else begin
                    n_rem = shifted[vsm_pkg::SUM_W-1:0];
                    n_quo = {r_quo[15:0], 1'b0};
                end
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd16) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_data = r_quo[16] ? 16'hFFFF : r_quo[15:0];
                    n_out_last = (r_idx == r_count);
                    if (r_idx == r_count) begin
                        n_state = ST_COLLECT;
                        n_count = '0;
                        n_max   = MAX_RESET;
                        n_sum   = '0;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_COLLECT;
            r_count   <= '0;
            r_max     <= MAX_RESET;
            r_sum     <= '0;
            r_idx     <= '0;
            r_got     <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_max     <= n_max;
            r_sum     <= n_sum;
            r_idx     <= n_idx;
            r_got     <= n_got;
            r_out_vld <= n_out_vld;
            r_rd_vld  <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_ebit     <= n_ebit;
        r_dcnt     <= n_dcnt;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

[hdl/vsm_checker.sv]
// ----------------------------------------------------------------------------
// vsm_checker
// Port-level checks on the softmax block, bound to the top level.
// ----------------------------------------------------------------------------
module vsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // a closing item stops intake until the vector is drained
    a_close_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input accepted right after closing item");

    // results are only produced while intake is stopped
    a_out_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while collecting");

    // no result right out of reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind vector_softmax vsm_checker u_vsm_checker (.*);
